// File: hdl/assert_macros.svh
// Assertion macros for the files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked on every rising clock edge while the block is out of reset.
`define SBUS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SBUS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SBUS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SBUS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: hdl/sbus_pkg.sv
// Shared types and constants of the SBUS frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package sbus_pkg;

    // Frame layout: header, 22 data bytes, flag byte, footer.
    localparam int FRAME_BYTES = 25;
    localparam int STORE_BYTES = FRAME_BYTES - 2;
    localparam int DATA_BYTES  = STORE_BYTES - 1;
    localparam int STORE_W     = STORE_BYTES * 8;
    localparam int DATA_W      = DATA_BYTES * 8;
    localparam int POS_W       = 5;
    localparam logic [POS_W-1:0] FOOTER_POS = POS_W'(FRAME_BYTES - 1);

    // Channels per good frame.
    localparam int NUM_PROP  = 16;
    localparam int NUM_CH    = 18;
    localparam int CH_W      = 5;
    localparam int CH_BITS   = 11;
    localparam int OFF_W     = 8;
    localparam logic [CH_W-1:0] CH_FLAG0 = CH_W'(NUM_PROP);
    localparam logic [CH_W-1:0] CH_FLAG1 = CH_W'(NUM_PROP + 1);
    localparam logic [CH_BITS-1:0] CH_MASK = 11'h7FF;

    // Footer nibble mask.
    localparam logic [7:0] NIBBLE_MASK = 8'h0F;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0] HEADER_RST = 8'd15;
    localparam logic [7:0] FOOTER_RST = 8'd0;
    localparam logic [3:0] NIBBLE_RST = 4'd4;

    // Frame queue between the deframer and the channel unpacker.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_CHANNEL = 2'd0,
        ST_HDR_ERR = 2'd1,
        ST_FTR_ERR = 2'd2
    } t_status;

    // One queued job: a good frame or an error word.
    typedef struct packed {
        t_status             status;
        logic [STORE_W-1:0]  frame;
    } t_entry;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

// File: hdl/sbus_front.sv
// Deframer: configuration registers, byte position, frame shift line and footer check.
`timescale 1ns / 1ps
`default_nettype none

module sbus_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [sbus_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [7:0]                      i_cfg_data,
    input  wire logic                            i_accept,
    input  wire logic [7:0]                      i_rx_byte,
    output      logic                            o_qpush,
    output      sbus_pkg::t_entry                o_entry
);

    logic [7:0]                      r_header;
    logic [7:0]                      r_footer;
    logic [3:0]                      r_nibble;
    logic [sbus_pkg::POS_W-1:0]      r_pos;
    logic [sbus_pkg::POS_W-1:0]      n_pos;
    logic [sbus_pkg::STORE_W-1:0]    r_shift;
    logic                            footer_ok;
    logic                            is_footer;

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= sbus_pkg::HEADER_RST;
            r_footer <= sbus_pkg::FOOTER_RST;
            r_nibble <= sbus_pkg::NIBBLE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sbus_pkg::CFG_HEADER: r_header <= i_cfg_data;
                sbus_pkg::CFG_FOOTER: r_footer <= i_cfg_data;
                sbus_pkg::CFG_NIBBLE: r_nibble <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign is_footer = (r_pos >= sbus_pkg::FOOTER_POS);
    assign footer_ok = (i_rx_byte == r_footer) ||
                       ((i_rx_byte & sbus_pkg::NIBBLE_MASK) == {4'd0, r_nibble});

    // Byte position and queue write for each accepted word.
    always_comb begin
        n_pos          = r_pos;
        o_qpush        = 1'b0;
        o_entry.status = sbus_pkg::ST_CHANNEL;
        o_entry.frame  = r_shift;
        if (i_accept) begin
            if (r_pos == '0) begin
                if (i_rx_byte != r_header) begin
                    o_qpush        = 1'b1;
                    o_entry.status = sbus_pkg::ST_HDR_ERR;
                end else begin
                    n_pos = sbus_pkg::POS_W'(1);
                end
            end else if (!is_footer) begin
                n_pos = r_pos + sbus_pkg::POS_W'(1);
            end else begin
                n_pos          = '0;
                o_qpush        = 1'b1;
                o_entry.status = footer_ok ? sbus_pkg::ST_CHANNEL : sbus_pkg::ST_FTR_ERR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // Body bytes shift in from the top; after 23 bytes the first sits at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_accept && (r_pos != '0) && !is_footer) begin
            r_shift <= {i_rx_byte, r_shift[sbus_pkg::STORE_W-1:8]};
        end
    end

endmodule

`default_nettype wire

// File: hdl/sbus_queue.sv
// Short queue of frame jobs between the deframer and the channel unpacker.
`timescale 1ns / 1ps
`default_nettype none

module sbus_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire sbus_pkg::t_entry  i_entry,
    input  wire logic              i_pop,
    output sbus_pkg::t_entry       o_head,
    output sbus_pkg::t_qstat       o_stat
);

    sbus_pkg::t_entry                r_mem [sbus_pkg::QDEPTH];
    logic [sbus_pkg::QPTR_W-1:0]     r_wr;
    logic [sbus_pkg::QPTR_W-1:0]     r_rd;
    logic [sbus_pkg::QCNT_W-1:0]     r_cnt;
    logic                            do_push;
    logic                            do_pop;

    assign o_stat.full  = (r_cnt == sbus_pkg::QCNT_W'(sbus_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + sbus_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + sbus_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + sbus_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - sbus_pkg::QCNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// File: hdl/sbus_back.sv
// Channel unpacker: walks the head job and presents one result word at a time.
`timescale 1ns / 1ps
`default_nettype none

module sbus_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire sbus_pkg::t_entry                 i_head,
    input  wire logic                             i_qempty,
    input  wire logic                             i_pop,
    output      logic                             o_qpop,
    output      logic [1:0]                       o_status,
    output      logic [sbus_pkg::CH_W-1:0]        o_channel_index,
    output      logic [sbus_pkg::CH_BITS-1:0]     o_channel_value,
    output      logic                             o_last
);

    logic [sbus_pkg::CH_W-1:0]       r_ch;
    logic [sbus_pkg::OFF_W-1:0]      bit_off;
    logic [sbus_pkg::DATA_W-1:0]     data_bits;
    logic [7:0]                      flags;
    logic                            taken;

    assign data_bits = i_head.frame[sbus_pkg::DATA_W-1:0];
    assign flags     = i_head.frame[sbus_pkg::STORE_W-1:sbus_pkg::DATA_W];
    assign bit_off   = sbus_pkg::OFF_W'(r_ch[3:0]) * sbus_pkg::OFF_W'(sbus_pkg::CH_BITS);
    assign taken     = i_pop && !i_qempty;

    // Result word for the current channel of the head job.
    always_comb begin
        o_status        = i_head.status;
        o_channel_index = '0;
        o_channel_value = '0;
        o_last          = 1'b1;
        if (i_head.status == sbus_pkg::ST_CHANNEL) begin
            o_channel_index = r_ch;
            o_last          = (r_ch == sbus_pkg::CH_FLAG1);
            if (r_ch == sbus_pkg::CH_FLAG0) begin
                o_channel_value = {10'd0, flags[0]};
            end else if (r_ch == sbus_pkg::CH_FLAG1) begin
                o_channel_value = {9'd0, flags[1], 1'b0};
            end else begin
                o_channel_value = data_bits[bit_off +: sbus_pkg::CH_BITS] & sbus_pkg::CH_MASK;
            end
        end
    end

    // The job leaves the queue with its last word.
    assign o_qpop = taken && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch <= '0;
        end else if (taken) begin
            r_ch <= o_last ? '0 : r_ch + sbus_pkg::CH_W'(1);
        end
    end

endmodule

`default_nettype wire

// File: hdl/sbus_frame_receiver.sv
// Top level of the SBUS frame receiver: deframer, job queue and channel unpacker.
//
//  channel   direction  handshake           words
//  input     in         i_push / o_full     i_rx_byte
//  result    out        o_empty / i_pop     o_status, o_channel_index, o_channel_value, o_last
//  config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// One byte is taken every cycle unless the four-entry job queue is full.
// A good frame drains as 18 result words, one per cycle while i_pop is held, set by the
// unpacker's channel counter; an error drains as a single word.
// A frame's first result reaches the ports once its job is at the head of the queue.
// Reset is synchronous and clears the byte position, queue and channel counter.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sbus_frame_receiver (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_push,
    output      logic                             o_full,
    input  wire logic [7:0]                       i_rx_byte,
    output      logic                             o_empty,
    input  wire logic                             i_pop,
    output      logic [1:0]                       o_status,
    output      logic [sbus_pkg::CH_W-1:0]        o_channel_index,
    output      logic [sbus_pkg::CH_BITS-1:0]     o_channel_value,
    output      logic                             o_last,
    input  wire logic                             i_cfg_we,
    input  wire logic [sbus_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [7:0]                       i_cfg_data
);

    sbus_pkg::t_entry   entry;
    sbus_pkg::t_entry   head;
    sbus_pkg::t_qstat   qstat;
    logic               qpush;
    logic               qpop;
    logic               accept;

    assign o_full  = qstat.full;
    assign o_empty = qstat.empty;
    assign accept  = i_push && !qstat.full;

    sbus_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_rx_byte  (i_rx_byte),
        .o_qpush    (qpush),
        .o_entry    (entry)
    );

    sbus_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (qpush),
        .i_entry (entry),
        .i_pop   (qpop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    sbus_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_qempty        (qstat.empty),
        .i_pop           (i_pop),
        .o_qpop          (qpop),
        .o_status        (o_status),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last          (o_last)
    );

    // The queue is never full and empty at once.
    `SBUS_ASSERT(a_qstat_excl, i_clk, i_rst_n, !(qstat.full && qstat.empty), "queue full and empty")

    // A channel word that closes a job is always the second flag channel.
    `SBUS_ASSERT(a_last_is_flag1, i_clk, i_rst_n, (!o_empty && o_status == sbus_pkg::ST_CHANNEL && o_last) |-> (o_channel_index == sbus_pkg::CH_FLAG1), "last word not on channel 17")

    // Error words close their job and carry channel zero.
    `SBUS_ASSERT(a_err_single, i_clk, i_rst_n, (!o_empty && o_status != sbus_pkg::ST_CHANNEL) |-> (o_last && o_channel_index == '0), "error word malformed")

    // Taking a word that is not last moves on to the next channel of the same job.
    `SBUS_ASSERT(a_ch_step, i_clk, i_rst_n, (!o_empty && i_pop && !o_last) |=> (!o_empty && o_channel_index == $past(o_channel_index) + 5'd1), "channel sequence broken")

endmodule

`default_nettype wire
